// ----- sv/spq_pkg.sv -----
// Package for the sorted priority queue: item types, command and status codes,
// and the key normalization and case folding functions. No dependencies.
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_CHARS_DEF = 8;
    localparam int KEY_W         = 64;
    localparam int OCC_W         = 5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXTRACT,
        S_SCAN,
        S_PUT_HEAD
    } t_state;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    // A key ends at its first zero byte or after nchars characters.
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k,
                                                       input int nchars);
        logic [KEY_W-1:0] res;
        logic             alive;
        logic [7:0]       b;
        res   = '0;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            b = k[KEY_W-1-8*i -: 8];
            if (i >= nchars || b == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                res[KEY_W-1-8*i -: 8] = b;
            end
        end
        return res;
    endfunction

    // Lower-case letters map to upper case so that the word orders as an integer.
    function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic [7:0]       b;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            b = k[8*i +: 8];
            if (b inside {[8'h61:8'h7A]}) begin
                b = b - 8'h20;
            end
            res[8*i +: 8] = b;
        end
        return res;
    endfunction

endpackage

// ----- sv/spq_keycmp.sv -----
// Case-insensitive key compare for the sorted priority queue.
// Depends on spq_pkg for the folding function.
module spq_keycmp import spq_pkg::*; #(
    parameter int KW = 8 * KEY_CHARS_DEF
) (
    input  logic [KW-1:0] i_entry,
    input  logic [KW-1:0] i_fold,
    output logic          o_less
);

    logic [KEY_W-1:0] entry_ext;
    logic [KEY_W-1:0] entry_fold;

    always_comb begin
        entry_ext  = KEY_W'(i_entry) << (KEY_W - KW);
        entry_fold = fold_case(entry_ext);
        o_less     = entry_fold[KEY_W-1 -: KW] < i_fold;
    end

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue of short text keys, kept in one on-chip memory.
// Depends on spq_pkg and spq_keycmp.
//
// Usage: drive i_item and raise start while busy is low; the item is taken at
// that clock edge. Exactly one result per item appears on o_result for one
// cycle, marked by o_done, and the receiver cannot hold it off.
// The keys sit in a circular buffer in memory, smallest at the head pointer.
// Extract reads the head entry into the read register and advances the head in
// the S_EXTRACT state, from which the result is registered.
// Enqueue walks from the tail toward the head, one entry per cycle, reading
// an entry and writing it one place further until a strictly smaller key is
// found; the single memory read port sets this pace. An item that lands at
// position zero ends with the S_PUT_HEAD state, which writes the new head.
// Enqueue into an empty table, extract from an empty table and enqueue into a
// full table answer in the cycle after acceptance.
// A new item may be taken while the previous result is on the outputs.
// Reset clears the entry count and head pointer; memory contents are never
// cleared because entries beyond the count are never read.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_CHARS = KEY_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = 8 * KEY_CHARS;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic [KW-1:0]   r_key, n_key;
    logic [KW-1:0]   r_fold, n_fold;
    logic            r_done, n_done;
    t_out_item       r_result, n_result;

    logic [KW-1:0]   r_mem [DEPTH];
    logic [KW-1:0]   r_rdata;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [KW-1:0]   mem_wdata;

    logic [KEY_W-1:0] in_norm;
    logic [KEY_W-1:0] in_fold;
    logic             entry_less;

    // Physical address of logical position idx behind the head.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] idx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, idx};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    spq_keycmp #(.KW(KW)) u_keycmp (
        .i_entry (r_rdata),
        .i_fold  (r_fold),
        .o_less  (entry_less)
    );

    assign in_norm = normalize_key(i_item.key_in, KEY_CHARS);
    assign in_fold = fold_case(in_norm);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.command == CMD_EXTRACT) begin
                        if (r_count != '0) begin
                            n_state = S_EXTRACT;
                        end
                    end else if (r_count != '0 && r_count < CW'(DEPTH)) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_EXTRACT: n_state = S_IDLE;
            S_SCAN: begin
                if (entry_less) begin
                    n_state = S_IDLE;
                end else if (r_idx == '0) begin
                    n_state = S_PUT_HEAD;
                end
            end
            S_PUT_HEAD: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and results.
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_fold    = r_fold;
        n_done    = 1'b0;
        n_result  = '{key_out: '0, status: ST_INSERTED, occupancy: OCC_W'(r_count)};
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_head;
        mem_raddr = r_head;
        mem_wdata = r_key;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key  = in_norm[KEY_W-1 -: KW];
                    n_fold = in_fold[KEY_W-1 -: KW];
                    if (i_item.command == CMD_EXTRACT) begin
                        if (r_count == '0) begin
                            n_done          = 1'b1;
                            n_result.status = ST_EMPTY;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = r_head;
                        end
                    end else if (r_count >= CW'(DEPTH)) begin
                        n_done          = 1'b1;
                        n_result.status = ST_FULL;
                    end else if (r_count == '0) begin
                        mem_we             = 1'b1;
                        mem_waddr          = r_head;
                        mem_wdata          = in_norm[KEY_W-1 -: KW];
                        n_count            = CW'(1);
                        n_done             = 1'b1;
                        n_result.status    = ST_INSERTED;
                        n_result.occupancy = OCC_W'(1);
                    end else begin
                        n_idx     = AW'(r_count - CW'(1));
                        mem_re    = 1'b1;
                        mem_raddr = phys(r_head, AW'(r_count - CW'(1)));
                    end
                end
            end
            S_EXTRACT: begin
                n_head             = phys(r_head, AW'(1));
                n_count            = r_count - CW'(1);
                n_done             = 1'b1;
                n_result.key_out   = KEY_W'(r_rdata) << (KEY_W - KW);
                n_result.status    = ST_EXTRACTED;
                n_result.occupancy = OCC_W'(r_count - CW'(1));
            end
            S_SCAN: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_idx + AW'(1));
                if (entry_less) begin
                    // The new key goes right behind the first smaller entry.
                    mem_wdata          = r_key;
                    n_count            = r_count + CW'(1);
                    n_done             = 1'b1;
                    n_result.status    = ST_INSERTED;
                    n_result.occupancy = OCC_W'(r_count + CW'(1));
                end else begin
                    mem_wdata = r_rdata;
                    if (r_idx != '0) begin
                        n_idx     = r_idx - AW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = phys(r_head, r_idx - AW'(1));
                    end
                end
            end
            S_PUT_HEAD: begin
                mem_we             = 1'b1;
                mem_waddr          = r_head;
                mem_wdata          = r_key;
                n_count            = r_count + CW'(1);
                n_done             = 1'b1;
                n_result.status    = ST_INSERTED;
                n_result.occupancy = OCC_W'(r_count + CW'(1));
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_fold   <= n_fold;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
